/* rtl/dpb_pkg.sv */
// ----------------------------------------------------------------------------
// Depth pixel backprojection package
// Shared constants, register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_UNITS_DEFAULT = 1000;
  localparam int COORD_BITS_DEFAULT  = 16;

  // Quotient bits produced by the divider, one per pipeline stage.
  localparam int QUOT_BITS = 32;
  // Fraction bits of the Q16.16 result.
  localparam int FRAC_BITS = 16;

  // Depth used when the sensor reports no reading.
  localparam logic [15:0] NO_READING_DEPTH = 16'hFFFF;

  // Saturation bounds of a signed 32-bit result, as magnitudes.
  localparam logic [QUOT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUOT_BITS-1:0] SAT_NEG = 32'h8000_0000;

  // Identity value of a Q8.24 matrix entry.
  localparam logic signed [31:0] Q824_ONE = 32'sh0100_0000;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_DEPTH_THRESHOLD = 4'd0,
    REG_CROP_COLUMNS    = 4'd1,
    REG_CROP_ROWS       = 4'd2,
    REG_INV_MATRIX_A    = 4'd3,
    REG_INV_MATRIX_B    = 4'd4,
    REG_INV_MATRIX_C    = 4'd5,
    REG_INV_MATRIX_D    = 4'd6,
    REG_INV_MATRIX_E    = 4'd7
  } cfg_reg_t;

  // Decoded configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0]        threshold;
    logic [15:0]        col_first;
    logic [15:0]        col_last;
    logic [15:0]        row_first;
    logic [15:0]        row_last;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } dpb_cfg_t;

endpackage

/* rtl/depth_pixel_backprojection_unit.sv */
// ----------------------------------------------------------------------------
// Depth pixel backprojection unit
// Turns depth pixels into 3-D points in Q16.16 metres.
// ----------------------------------------------------------------------------
// The unit takes one depth pixel per clock while its output is not stalled
// and returns its back-projected point through the filtering and matrix
// product stages A to C, the divide setup stages D and E, and a 32-stage
// restoring divider with its entry and output registers. Pixels that fail
// the depth threshold or the crop window, or whose third projected component
// is zero, produce no beat. A stalled output holds the whole pipeline.
// Configuration must be written while the unit is idle; it is not enforced.
module depth_pixel_backprojection_unit import dpb_pkg::*; #(
  parameter int DEPTH_UNITS_PER_METER = DEPTH_UNITS_DEFAULT,
  parameter int COORD_BITS            = COORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pixel_column, pixel_row, raw_depth
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // point_x, point_y, point_z
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PW = COORD_BITS + 35;
  localparam int NW = PW + 16;
  localparam int DW = PW + 16;

  dpb_cfg_t             cfg;
  logic                 adv;

  logic                 f_valid;
  logic signed [PW-1:0] f_p0, f_p1, f_p2;
  logic [15:0]          f_depth;

  logic                 e_valid;
  logic [NW-1:0]        e_num [3];
  logic                 e_neg [3];
  logic [DW-1:0]        e_den;

  logic signed [QUOT_BITS-1:0] point [3];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= 16'hFFFF;
      cfg.col_first <= '0;
      cfg.col_last  <= 16'hFFFF;
      cfg.row_first <= '0;
      cfg.row_last  <= 16'hFFFF;
      cfg.m00       <= Q824_ONE;
      cfg.m01       <= '0;
      cfg.m02       <= '0;
      cfg.m10       <= '0;
      cfg.m11       <= Q824_ONE;
      cfg.m12       <= '0;
      cfg.m20       <= '0;
      cfg.m21       <= '0;
      cfg.m22       <= Q824_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEPTH_THRESHOLD: cfg.threshold <= cfg_data[15:0];
        REG_CROP_COLUMNS: begin
          cfg.col_first <= cfg_data[15:0];
          cfg.col_last  <= cfg_data[31:16];
        end
        REG_CROP_ROWS: begin
          cfg.row_first <= cfg_data[15:0];
          cfg.row_last  <= cfg_data[31:16];
        end
        REG_INV_MATRIX_A: begin
          cfg.m00 <= cfg_data[31:0];
          cfg.m01 <= cfg_data[63:32];
        end
        REG_INV_MATRIX_B: begin
          cfg.m02 <= cfg_data[31:0];
          cfg.m10 <= cfg_data[63:32];
        end
        REG_INV_MATRIX_C: begin
          cfg.m11 <= cfg_data[31:0];
          cfg.m12 <= cfg_data[63:32];
        end
        REG_INV_MATRIX_D: begin
          cfg.m20 <= cfg_data[31:0];
          cfg.m21 <= cfg_data[63:32];
        end
        REG_INV_MATRIX_E: cfg.m22 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  dpb_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (s_axis_tvalid),
    .pixel_column(s_axis_tdata[15:0]),
    .pixel_row   (s_axis_tdata[31:16]),
    .raw_depth   (s_axis_tdata[47:32]),
    .cfg         (cfg),
    .out_valid   (f_valid),
    .p0          (f_p0),
    .p1          (f_p1),
    .p2          (f_p2),
    .depth       (f_depth)
  );

  dpb_prep #(
    .DEPTH_UNITS_PER_METER(DEPTH_UNITS_PER_METER),
    .PW                   (PW)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_valid),
    .p0       (f_p0),
    .p1       (f_p1),
    .p2       (f_p2),
    .depth    (f_depth),
    .out_valid(e_valid),
    .num      (e_num),
    .neg      (e_neg),
    .den      (e_den)
  );

  dpb_divider #(
    .NW(NW),
    .DW(DW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (e_valid),
    .num      (e_num),
    .neg      (e_neg),
    .den      (e_den),
    .out_valid(m_axis_tvalid),
    .result   (point)
  );

  // Output beat, x in the lowest bits.
  assign m_axis_tdata = {point[2], point[1], point[0]};

endmodule

/* rtl/dpb_front.sv */
// ----------------------------------------------------------------------------
// Depth pixel backprojection front end
// Pixel filtering and the matrix-vector product p = M * [u, v, 1].
// ----------------------------------------------------------------------------
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int PW = COORD_BITS + 35
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [15:0]          pixel_column,
  input  logic [15:0]          pixel_row,
  input  logic [15:0]          raw_depth,
  input  dpb_cfg_t             cfg,
  output logic                 out_valid,
  output logic signed [PW-1:0] p0,
  output logic signed [PW-1:0] p1,
  output logic signed [PW-1:0] p2,
  output logic [15:0]          depth
);

  localparam int QW = COORD_BITS + 33;

  logic [COORD_BITS-1:0] u_in;
  logic [COORD_BITS-1:0] v_in;
  logic [15:0]           depth_in;
  logic                  keep_in;

  logic                  a_valid;
  logic [COORD_BITS-1:0] a_u;
  logic [COORD_BITS-1:0] a_v;
  logic [15:0]           a_depth;

  logic                  b_valid;
  logic [15:0]           b_depth;
  logic signed [QW-1:0]  b_00, b_01, b_10, b_11, b_20, b_21;

  logic signed [PW-1:0]  sum0, sum1, sum2;

  // Coordinate masking, missing-depth substitution and the keep test.
  assign u_in     = pixel_column[COORD_BITS-1:0];
  assign v_in     = pixel_row[COORD_BITS-1:0];
  assign depth_in = (raw_depth == '0) ? NO_READING_DEPTH : raw_depth;
  assign keep_in  = in_valid && (depth_in < cfg.threshold) &&
                    (16'(u_in) >= cfg.col_first) && (16'(u_in) <= cfg.col_last) &&
                    (16'(v_in) >= cfg.row_first) && (16'(v_in) <= cfg.row_last);

  // Stage A: filtered pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= keep_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_u     <= u_in;
      a_v     <= v_in;
      a_depth <= depth_in;
    end
  end

  // Stage B: the six coordinate products.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_depth <= a_depth;
      b_00    <= QW'(cfg.m00) * QW'($signed({1'b0, a_u}));
      b_01    <= QW'(cfg.m01) * QW'($signed({1'b0, a_v}));
      b_10    <= QW'(cfg.m10) * QW'($signed({1'b0, a_u}));
      b_11    <= QW'(cfg.m11) * QW'($signed({1'b0, a_v}));
      b_20    <= QW'(cfg.m20) * QW'($signed({1'b0, a_u}));
      b_21    <= QW'(cfg.m21) * QW'($signed({1'b0, a_v}));
    end
  end

  // Stage C: row sums; a zero third component drops the pixel.
  assign sum0 = PW'(b_00) + PW'(b_01) + PW'(cfg.m02);
  assign sum1 = PW'(b_10) + PW'(b_11) + PW'(cfg.m12);
  assign sum2 = PW'(b_20) + PW'(b_21) + PW'(cfg.m22);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= b_valid && (sum2 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0    <= sum0;
      p1    <= sum1;
      p2    <= sum2;
      depth <= b_depth;
    end
  end

endmodule

/* rtl/dpb_prep.sv */
// ----------------------------------------------------------------------------
// Depth pixel backprojection divide setup
// Splits signs from magnitudes and forms the dividends and the divisor.
// ----------------------------------------------------------------------------
module dpb_prep import dpb_pkg::*; #(
  parameter int DEPTH_UNITS_PER_METER = DEPTH_UNITS_DEFAULT,
  parameter int PW = COORD_BITS_DEFAULT + 35,
  localparam int NW = PW + 16,
  localparam int DW = PW + 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [PW-1:0] p0,
  input  logic signed [PW-1:0] p1,
  input  logic signed [PW-1:0] p2,
  input  logic [15:0]          depth,
  output logic                 out_valid,
  output logic [NW-1:0]        num [3],
  output logic                 neg [3],
  output logic [DW-1:0]        den
);

  localparam logic [15:0] UNITS = 16'(DEPTH_UNITS_PER_METER);

  logic          d_valid;
  logic [PW-1:0] d_mag [3];
  logic          d_neg [3];
  logic [15:0]   d_depth;

  // Stage D: magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_mag[0] <= p0[PW-1] ? PW'(-p0) : PW'(p0);
      d_mag[1] <= p1[PW-1] ? PW'(-p1) : PW'(p1);
      d_mag[2] <= p2[PW-1] ? PW'(-p2) : PW'(p2);
      d_neg[0] <= p0[PW-1] ^ p2[PW-1];
      d_neg[1] <= p1[PW-1] ^ p2[PW-1];
      d_neg[2] <= 1'b0;
      d_depth  <= depth;
    end
  end

  // Stage E: dividend |p_i| * depth and divisor |p2| * units.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        num[l] <= NW'(d_mag[l]) * NW'(d_depth);
        neg[l] <= d_neg[l];
      end
      den <= DW'(d_mag[2]) * DW'(UNITS);
    end
  end

endmodule

/* rtl/dpb_divider.sv */
// ----------------------------------------------------------------------------
// Depth pixel backprojection divider
// Three-lane restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module dpb_divider import dpb_pkg::*; #(
  parameter int NW = 67,
  parameter int DW = 67
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [NW-1:0]               num [3],
  input  logic                        neg [3],
  input  logic [DW-1:0]               den,
  output logic                        out_valid,
  output logic signed [QUOT_BITS-1:0] result [3]
);

  localparam int QB    = QUOT_BITS;
  localparam int WW    = DW + QB + 1;
  localparam int LANES = 3;

  logic                v  [QB+1];
  logic [DW-1:0]       dq [QB];
  logic [WW-1:0]       r  [LANES][QB];
  logic [QB-1:0]       q  [LANES][QB+1];
  logic                sg [LANES][QB+1];
  logic                st [LANES][QB+1];

  logic [WW-1:0]       den_top;
  logic [WW-1:0]       num_sh [LANES];

  // Entry stage: dividend scaled by 2^16 and the overflow test.
  assign den_top = WW'({den, {QB{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq[0] <= den;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_entry
    assign num_sh[l] = WW'({num[l], {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk) begin
      if (adv) begin
        r[l][0]  <= num_sh[l];
        q[l][0]  <= '0;
        sg[l][0] <= neg[l];
        st[l][0] <= num_sh[l] >= den_top;
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int B = QB - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end

    // The divisor and remainder are not needed after the last stage.
    if (k < QB) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          dq[k] <= dq[k-1];
        end
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [WW-1:0] ds;
      logic          ge;

      assign ds = WW'(dq[k-1]) << B;
      assign ge = r[l][k-1] >= ds;

      always_ff @(posedge clk) begin
        if (adv) begin
          q[l][k]  <= q[l][k-1] | (QB'(ge) << B);
          sg[l][k] <= sg[l][k-1];
          st[l][k] <= st[l][k-1];
        end
      end

      if (k < QB) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            r[l][k] <= ge ? (r[l][k-1] - ds) : r[l][k-1];
          end
        end
      end
    end
  end

  // Output register: clamp, then apply the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[QB];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    logic [QB-1:0] limit;
    logic [QB-1:0] mag;

    assign limit = sg[l][QB] ? SAT_NEG : SAT_POS;
    assign mag   = (st[l][QB] || (q[l][QB] > limit)) ? limit : q[l][QB];

    always_ff @(posedge clk) begin
      if (adv) begin
        result[l] <= sg[l][QB] ? $signed(QB'(-mag)) : $signed(mag);
      end
    end
  end

endmodule
